/* hdl/ulc_pkg.sv */
// Shared constants, widths and types for the ultrasound log compression block.
package ulc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;

    localparam int AMP_W = 16;
    localparam int LIM_W = 10;
    localparam int PIX_W = 8;
    localparam int IDX_W = 4;
    localparam int CFG_W = 16;

    localparam int X_W   = (SAMPLE_BITS < AMP_W) ? SAMPLE_BITS : AMP_W;
    localparam int TOP_W = $clog2(X_W);
    localparam int L_W   = TOP_W + FRAC_BITS;

    localparam int MANT_BITS = 30;
    localparam int M_W       = MANT_BITS + 1;
    localparam int SH_W      = $clog2(M_W);

    localparam int LQ_SCALE = 2000;
    localparam int LQ_W     = L_W + 11;

    localparam int SPAN    = 2 * SAMPLE_BITS - 1;
    localparam int LIM_MAX = 2 ** LIM_W - 1;
    localparam int SPL_W   = $clog2(SPAN * LIM_MAX + 1);
    localparam int LIMQ_W  = SPL_W + FRAC_BITS;
    localparam int Q_W     = (LQ_W > LIMQ_W) ? LQ_W : LIMQ_W;

    localparam int PIX_MAX   = 2 ** PIX_W - 1;
    localparam int PIX_SCALE = 2 * PIX_MAX;
    localparam int N_W       = Q_W + PIX_W + 1;

    localparam logic [LIM_W-1:0] LOW_RESET  = LIM_W'(0);
    localparam logic [LIM_W-1:0] HIGH_RESET = LIM_W'(1000);

    localparam logic [IDX_W-1:0] REG_LOW_LIMIT  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_HIGH_LIMIT = IDX_W'(1);

    typedef struct packed {
        logic [Q_W-1:0] loq;
        logic [Q_W-1:0] den;
        logic           empty;
    } t_window;

endpackage

/* hdl/ulc_log2.sv */
// Fixed-point log2 pipeline: leading-one search, normalisation and one squaring stage per bit.
module ulc_log2
    import ulc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [AMP_W-1:0] i_amp,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [L_W-1:0]   o_log
);

    localparam int NST = FRAC_BITS + 2;

    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   w_en;
    logic [NST-1:0]   w_vin;
    logic [X_W-1:0]   r_x;
    logic [X_W-1:0]   n_x;
    logic [TOP_W-1:0] r_top;
    logic [TOP_W-1:0] n_top;
    logic [SH_W-1:0]  w_sh;
    logic [M_W-1:0]   r_m [0:FRAC_BITS-1];
    logic [L_W-1:0]   r_l [0:FRAC_BITS];

    assign w_en[NST-1] = !r_vld[NST-1] || i_ready;

    genvar k;
    for (k = 0; k < NST - 1; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign w_vin = {r_vld[NST-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= w_vin[i];
                end
            end
        end
    end

    always_comb begin
        n_x = i_amp[X_W-1:0];
        if (n_x == '0) begin
            n_x = X_W'(1);
        end
        n_top = '0;
        for (int i = 1; i < X_W; i++) begin
            if (n_x[i]) begin
                n_top = TOP_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x   <= n_x;
            r_top <= n_top;
        end
    end

    assign w_sh = SH_W'(MANT_BITS) - SH_W'(r_top);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_m[0] <= M_W'(r_x) << w_sh;
            r_l[0] <= {r_top, {FRAC_BITS{1'b0}}};
        end
    end

    genvar j;
    for (j = 0; j < FRAC_BITS; j++) begin : g_sq
        logic [2*M_W-1:0] w_sq;
        logic [M_W:0]     w_t;
        logic [M_W-1:0]   n_m;
        logic [L_W-1:0]   n_l;

        assign w_sq = r_m[j] * r_m[j];
        assign w_t  = w_sq[MANT_BITS +: M_W+1];

        always_comb begin
            n_l = r_l[j];
            if (w_t[M_W]) begin
                n_m = w_t[M_W:1];
                n_l[FRAC_BITS-1-j] = 1'b1;
            end else begin
                n_m = w_t[M_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[j+2]) begin
                r_l[j+1] <= n_l;
            end
        end

        if (j < FRAC_BITS - 1) begin : g_mant
            always_ff @(posedge i_clk) begin
                if (w_en[j+2]) begin
                    r_m[j+1] <= n_m;
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NST-1];
    assign o_log   = r_l[FRAC_BITS];

endmodule

/* hdl/ulc_scale.sv */
// Window scaling pipeline: log to limit units, offset, clamp and dividend forming.
module ulc_scale
    import ulc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_window        i_win,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [L_W-1:0] i_log,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [N_W-1:0] o_rem
);

    localparam int NST = 4;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;
    logic [NST-1:0] w_vin;
    logic [Q_W-1:0] r_lq;
    logic [Q_W-1:0] n_lq;
    logic [Q_W:0]   w_sub;
    logic [Q_W-1:0] r_diff;
    logic [Q_W-1:0] n_diff;
    logic [Q_W-1:0] r_num;
    logic [Q_W-1:0] n_num;
    logic [N_W-1:0] r_n;
    logic [N_W-1:0] n_n;

    assign w_en[NST-1] = !r_vld[NST-1] || i_ready;

    genvar k;
    for (k = 0; k < NST - 1; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign w_vin = {r_vld[NST-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= w_vin[i];
                end
            end
        end
    end

    assign n_lq   = Q_W'(LQ_W'(i_log) * LQ_W'(LQ_SCALE));
    assign w_sub  = {1'b0, r_lq} - {1'b0, i_win.loq};
    assign n_diff = w_sub[Q_W] ? '0 : w_sub[Q_W-1:0];
    assign n_num  = (r_diff > i_win.den) ? i_win.den : r_diff;
    assign n_n    = N_W'(r_num) * N_W'(PIX_SCALE) + N_W'(i_win.den);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_lq <= n_lq;
        end
        if (w_en[1]) begin
            r_diff <= n_diff;
        end
        if (w_en[2]) begin
            r_num <= n_num;
        end
        if (w_en[3]) begin
            r_n <= n_n;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NST-1];
    assign o_rem   = r_n;

endmodule

/* hdl/ulc_div.sv */
// Restoring divider pipeline: one quotient bit of the rounded pixel per stage.
module ulc_div
    import ulc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_window          i_win,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [N_W-1:0]   i_rem,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_q
);

    localparam int NST = PIX_W;

    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   w_en;
    logic [NST-1:0]   w_vin;
    logic [N_W-1:0]   w_div;
    logic [N_W-1:0]   r_rem [0:NST-2];
    logic [PIX_W-1:0] r_q   [0:NST-1];

    assign w_en[NST-1] = !r_vld[NST-1] || i_ready;

    genvar k;
    for (k = 0; k < NST - 1; k++) begin : g_en
        assign w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign w_vin = {r_vld[NST-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < NST; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= w_vin[i];
                end
            end
        end
    end

    assign w_div = N_W'({i_win.den, 1'b0});

    genvar j;
    for (j = 0; j < NST; j++) begin : g_bit
        logic [N_W-1:0]   w_rem_in;
        logic [PIX_W-1:0] w_q_in;
        logic [N_W-1:0]   w_dk;
        logic             w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = i_rem;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_q_in   = r_q[j-1];
        end

        assign w_dk = w_div << (NST - 1 - j);
        assign w_ge = (w_rem_in >= w_dk);

        always_ff @(posedge i_clk) begin
            if (w_en[j]) begin
                r_q[j] <= {w_q_in[PIX_W-2:0], w_ge};
            end
        end

        if (j < NST - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (w_en[j]) begin
                    r_rem[j] <= w_ge ? (w_rem_in - w_dk) : w_rem_in;
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NST-1];
    assign o_q     = r_q[NST-1];

endmodule

/* hdl/ultrasound_log_compression.sv */
// Top level of the ultrasound log compression block: registers, window terms and pipeline.
//
//  Channel   Direction  Handshake                   Payload
//  input     in         i_valid / o_ready           i_amplitude
//  output    out        o_valid / i_ready           o_pixel
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One sample is taken per clock while o_ready is high; each result passes through
// 2 normalisation stages, 16 squaring stages, 4 scaling stages and 8 divider stages. Reset
// clears every stage valid and sets the limits to 0 and 1000. A stall at the output holds
// each stage only until a gap ahead of it opens, so the input keeps taking samples while
// bubbles remain in the pipeline.
module ultrasound_log_compression
    import ulc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [AMP_W-1:0] i_amplitude,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_pixel,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [LIM_W-1:0] r_low;
    logic [LIM_W-1:0] r_high;
    t_window          r_win;
    t_window          n_win;
    logic [Q_W-1:0]   w_hiq;

    logic             w_log_valid;
    logic             w_log_ready;
    logic [L_W-1:0]   w_log;
    logic             w_scl_valid;
    logic             w_scl_ready;
    logic [N_W-1:0]   w_rem;
    logic [PIX_W-1:0] w_q;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= LOW_RESET;
            r_high <= HIGH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LOW_LIMIT: begin
                    r_low <= i_cfg_data[LIM_W-1:0];
                end
                REG_HIGH_LIMIT: begin
                    r_high <= i_cfg_data[LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_win.loq   = Q_W'(SPL_W'(r_low * SPL_W'(SPAN))) << FRAC_BITS;
        w_hiq       = Q_W'(SPL_W'(r_high * SPL_W'(SPAN))) << FRAC_BITS;
        n_win.den   = w_hiq - n_win.loq;
        n_win.empty = (r_high <= r_low);
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    ulc_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_amp   (i_amplitude),
        .o_valid (w_log_valid),
        .i_ready (w_log_ready),
        .o_log   (w_log)
    );

    ulc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (r_win),
        .i_valid (w_log_valid),
        .o_ready (w_log_ready),
        .i_log   (w_log),
        .o_valid (w_scl_valid),
        .i_ready (w_scl_ready),
        .o_rem   (w_rem)
    );

    ulc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (r_win),
        .i_valid (w_scl_valid),
        .o_ready (w_scl_ready),
        .i_rem   (w_rem),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_q     (w_q)
    );

    assign o_pixel = r_win.empty ? '0 : w_q;

endmodule

/* hdl/ulc_checker.sv */
// Port-level checker for the ultrasound log compression block, bound to the top level.
module ulc_checker
    import ulc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [PIX_W-1:0] o_pixel,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0] i_cfg_data
);

    logic [LIM_W-1:0] r_low;
    logic [LIM_W-1:0] r_high;
    logic             w_in_xfer;

    assign w_in_xfer = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= LOW_RESET;
            r_high <= HIGH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_LOW_LIMIT) begin
                r_low <= i_cfg_data[LIM_W-1:0];
            end
            if (i_cfg_index == REG_HIGH_LIMIT) begin
                r_high <= i_cfg_data[LIM_W-1:0];
            end
        end
    end

    // A pending result must hold until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel))
        else $error("output changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown straight after reset");

    // An empty display window gives black pixels.
    a_empty_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_high <= r_low) |-> o_pixel == '0)
        else $error("non-zero pixel with an empty window");

    // No result can come out in the cycle after an idle, empty start.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) && !w_in_xfer |=> !o_valid)
        else $error("result without a preceding input transfer");

endmodule

bind ultrasound_log_compression ulc_checker u_ulc_checker (.*);

/* tb/sv/tb.sv */
// Self-checking testbench for the ultrasound log compression block.
`timescale 1ns / 100ps

module tb;
    import ulc_pkg::*;

    typedef struct packed {
        logic [LIM_W-1:0] lo;
        logic [LIM_W-1:0] hi;
        logic [AMP_W-1:0] amp;
        logic             known;
        logic [PIX_W-1:0] pixel;
    } t_row;

    localparam int N_ROWS = 20;
    localparam int RANDOM_SETTINGS = 12;
    localparam int SAMPLES_PER_SETTING = 70;
    localparam int PIPE_LATENCY = 30;

    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{10'd0,    10'd1000, 16'h0000, 1'b1, 8'd0},
        '{10'd0,    10'd1000, 16'h0001, 1'b1, 8'd0},
        '{10'd0,    10'd1000, 16'hFFFF, 1'b1, 8'd255},
        '{10'd0,    10'd1000, 16'h8000, 1'b0, 8'd0},
        '{10'd0,    10'd1000, 16'h7FFF, 1'b0, 8'd0},
        '{10'd0,    10'd1000, 16'h5555, 1'b0, 8'd0},
        '{10'd0,    10'd1000, 16'hAAAA, 1'b0, 8'd0},
        '{10'd0,    10'd1000, 16'h0002, 1'b0, 8'd0},
        '{10'd0,    10'd1000, 16'h0003, 1'b0, 8'd0},
        '{10'd500,  10'd500,  16'hFFFF, 1'b1, 8'd0},
        '{10'd500,  10'd500,  16'h0000, 1'b1, 8'd0},
        '{10'd600,  10'd400,  16'h3039, 1'b1, 8'd0},
        '{10'd1023, 10'd0,    16'hFFFF, 1'b1, 8'd0},
        '{10'd0,    10'd1023, 16'hFFFF, 1'b0, 8'd0},
        '{10'd0,    10'd1023, 16'h0001, 1'b1, 8'd0},
        '{10'd1022, 10'd1023, 16'hFFFF, 1'b1, 8'd255},
        '{10'd1022, 10'd1023, 16'h0001, 1'b1, 8'd0},
        '{10'd1000, 10'd1023, 16'hFFFF, 1'b0, 8'd0},
        '{10'd0,    10'd1,    16'h0001, 1'b1, 8'd0},
        '{10'd0,    10'd1,    16'h0002, 1'b1, 8'd255}
    };

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             o_ready;
    logic [AMP_W-1:0] i_amplitude = '0;
    logic             o_valid;
    logic             i_ready     = 1'b0;
    logic [PIX_W-1:0] o_pixel;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    logic [LIM_W-1:0] low_limit  = LOW_RESET;
    logic [LIM_W-1:0] high_limit = HIGH_RESET;

    logic [PIX_W-1:0] expected_pixels [$];
    logic [PIX_W-1:0] wanted_pixel;
    int unsigned      mismatch_count   = 0;
    int unsigned      pixels_checked   = 0;
    int unsigned      settings_applied = 0;
    int unsigned      empty_windows    = 0;
    int unsigned      burst_left       = 0;
    int unsigned      stall_mode       = 0;
    int unsigned      cycle_count      = 0;

    ultrasound_log_compression i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_amplitude (i_amplitude),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel     (o_pixel),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // The log2 is built bit by bit from repeated squaring of the normalised mantissa;
    // the log is scaled by 2000, each limit by SPAN * 2^FRAC_BITS, so all stay exact.
    function automatic logic [PIX_W-1:0] predict_pixel(input logic [AMP_W-1:0] amp,
                                                       input logic [LIM_W-1:0] lo,
                                                       input logic [LIM_W-1:0] hi);
        logic [63:0] x;
        logic [63:0] mant;
        logic [63:0] log_val;
        logic [63:0] lq;
        logic [63:0] loq;
        logic [63:0] hiq;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] pix;
        int          top;
        x = 64'(amp);
        if (x == 0) begin
            x = 1;
        end
        if (hi <= lo) begin
            return '0;
        end
        top = 0;
        while ((x >> (top + 1)) != 0) begin
            top++;
        end
        mant = x << (MANT_BITS - top);
        log_val = 64'(top) << FRAC_BITS;
        for (int i = FRAC_BITS - 1; i >= 0; i--) begin
            mant = (mant * mant) >> MANT_BITS;
            if (mant >= (64'd1 << (MANT_BITS + 1))) begin
                log_val[i] = 1'b1;
                mant = mant >> 1;
            end
        end
        lq  = log_val * 64'(LQ_SCALE);
        loq = (64'(SPAN) * 64'(lo)) << FRAC_BITS;
        hiq = (64'(SPAN) * 64'(hi)) << FRAC_BITS;
        num = (lq > loq) ? lq - loq : 64'd0;
        den = hiq - loq;
        if (num >= den) begin
            pix = 64'(PIX_MAX);
        end else begin
            pix = (64'(PIX_SCALE) * num + den) / (2 * den);
            if (pix > 64'(PIX_MAX)) begin
                pix = 64'(PIX_MAX);
            end
        end
        return PIX_W'(pix);
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (index == REG_LOW_LIMIT) begin
            low_limit = data[LIM_W-1:0];
        end else if (index == REG_HIGH_LIMIT) begin
            high_limit = data[LIM_W-1:0];
        end
    endtask

    // The upper data bits carry noise, and a write to an unused index is slipped in.
    task automatic apply_limits(input logic [LIM_W-1:0] lo, input logic [LIM_W-1:0] hi);
        logic [CFG_W-1:0] data;
        data = CFG_W'($urandom);
        write_reg(IDX_W'($urandom_range(REG_HIGH_LIMIT + 1, 2 ** IDX_W - 1)), data);
        data = CFG_W'($urandom);
        data[LIM_W-1:0] = lo;
        write_reg(REG_LOW_LIMIT, data);
        data = CFG_W'($urandom);
        data[LIM_W-1:0] = hi;
        write_reg(REG_HIGH_LIMIT, data);
        i_cfg_valid <= 1'b0;
        settings_applied++;
        if (hi <= lo) begin
            empty_windows++;
        end
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_sample(input logic [AMP_W-1:0] amp, input logic known,
                               input logic [PIX_W-1:0] known_pixel);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_amplitude <= amp;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        expected_pixels.insert(expected_pixels.size(),
                               known ? known_pixel : predict_pixel(amp, low_limit, high_limit));
        burst_left--;
    endtask

    function automatic logic [AMP_W-1:0] pick_amplitude();
        case ($urandom_range(0, 3))
            0: return AMP_W'($urandom);
            1: return AMP_W'($urandom) >> $urandom_range(0, AMP_W - 1);
            2: return AMP_W'($urandom_range(0, 15));
            default: return (AMP_W'(1) << $urandom_range(0, AMP_W - 1))
                            - AMP_W'($urandom_range(0, 1));
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            2: i_ready <= ($urandom_range(0, 5) == 0);
            default: i_ready <= cycle_count[0];
        endcase
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("pixel %0d transferred with no expectation pending", o_pixel);
                mismatch_count <= mismatch_count + 1;
            end else begin
                wanted_pixel = expected_pixels.pop_front();
                pixels_checked <= pixels_checked + 1;
                if (o_pixel !== wanted_pixel) begin
                    $error("pixel mismatch: expected %0d, actual %0d", wanted_pixel, o_pixel);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    initial begin
        logic [LIM_W-1:0] lo;
        logic [LIM_W-1:0] hi;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].lo != low_limit || DIRECTED_ROWS[r].hi != high_limit) begin
                drain_pipeline();
                apply_limits(DIRECTED_ROWS[r].lo, DIRECTED_ROWS[r].hi);
            end
            send_sample(DIRECTED_ROWS[r].amp, DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].pixel);
        end

        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            case ($urandom_range(0, 5))
                0: begin
                    lo = '0;
                    hi = LIM_W'(LIM_MAX);
                end
                1: begin
                    hi = LIM_W'($urandom);
                    lo = LIM_W'($urandom_range(hi, LIM_MAX));
                end
                2: begin
                    lo = LIM_W'($urandom_range(900, LIM_MAX - 1));
                    hi = LIM_W'(LIM_MAX);
                end
                default: begin
                    lo = LIM_W'($urandom_range(0, 900));
                    hi = LIM_W'($urandom_range(lo + 1, LIM_MAX));
                end
            endcase
            drain_pipeline();
            apply_limits(lo, hi);
            repeat (SAMPLES_PER_SETTING) send_sample(pick_amplitude(), 1'b0, '0);
        end

        drain_pipeline();
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d pixels across %0d limit settings (%0d with an empty window),",
                 pixels_checked, settings_applied, empty_windows);
        $display("with random input gaps, output back-pressure and ignored register writes.");
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/ulc_pkg.sv
hdl/ulc_log2.sv
hdl/ulc_scale.sv
hdl/ulc_div.sv
hdl/ultrasound_log_compression.sv
hdl/ulc_checker.sv
tb/sv/tb.sv
